/* sv/md5he_pkg.sv */
// Shared types, constants and round helper functions for the MD5 engine.
// No dependencies; the block buffer, the round unit and the top level import this package.
package md5he_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 61;

    typedef logic [3:0][WORD_W-1:0] t_words;

    // Chaining words after reset, A in entry 0.
    localparam t_words IV_WORDS = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LAST_POS     = 6'd63;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [1:0] LAST_OUT_IDX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic run;
    } t_round_ctl;

    typedef struct packed {
        logic       we;
        logic [5:0] addr;
        logic [7:0] data;
    } t_buf_wr;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] sel, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        case (sel)
            2'd0: begin
                return d ^ (b & (c ^ d));
            end
            2'd1: begin
                return c ^ (d & (c ^ b));
            end
            2'd2: begin
                return b ^ c ^ d;
            end
            default: begin
                return c ^ (b | ~d);
            end
        endcase
    endfunction

    // Message word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        r4 = r[3:0];
        case (r[5:4])
            2'd0: begin
                return r4;
            end
            2'd1: begin
                return r4 * 4'd5 + 4'd1;
            end
            2'd2: begin
                return r4 * 4'd3 + 4'd5;
            end
            default: begin
                return r4 * 4'd7;
            end
        endcase
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        case ({r[5:4], r[1:0]})
            4'd0:    return 5'd7;
            4'd1:    return 5'd12;
            4'd2:    return 5'd17;
            4'd3:    return 5'd22;
            4'd4:    return 5'd5;
            4'd5:    return 5'd9;
            4'd6:    return 5'd14;
            4'd7:    return 5'd20;
            4'd8:    return 5'd4;
            4'd9:    return 5'd11;
            4'd10:   return 5'd16;
            4'd11:   return 5'd23;
            4'd12:   return 5'd6;
            4'd13:   return 5'd10;
            4'd14:   return 5'd15;
            default: return 5'd21;
        endcase
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        case (r)
            6'd0:  return 32'hd76aa478;
            6'd1:  return 32'he8c7b756;
            6'd2:  return 32'h242070db;
            6'd3:  return 32'hc1bdceee;
            6'd4:  return 32'hf57c0faf;
            6'd5:  return 32'h4787c62a;
            6'd6:  return 32'ha8304613;
            6'd7:  return 32'hfd469501;
            6'd8:  return 32'h698098d8;
            6'd9:  return 32'h8b44f7af;
            6'd10: return 32'hffff5bb1;
            6'd11: return 32'h895cd7be;
            6'd12: return 32'h6b901122;
            6'd13: return 32'hfd987193;
            6'd14: return 32'ha679438e;
            6'd15: return 32'h49b40821;
            6'd16: return 32'hf61e2562;
            6'd17: return 32'hc040b340;
            6'd18: return 32'h265e5a51;
            6'd19: return 32'he9b6c7aa;
            6'd20: return 32'hd62f105d;
            6'd21: return 32'h02441453;
            6'd22: return 32'hd8a1e681;
            6'd23: return 32'he7d3fbc8;
            6'd24: return 32'h21e1cde6;
            6'd25: return 32'hc33707d6;
            6'd26: return 32'hf4d50d87;
            6'd27: return 32'h455a14ed;
            6'd28: return 32'ha9e3e905;
            6'd29: return 32'hfcefa3f8;
            6'd30: return 32'h676f02d9;
            6'd31: return 32'h8d2a4c8a;
            6'd32: return 32'hfffa3942;
            6'd33: return 32'h8771f681;
            6'd34: return 32'h6d9d6122;
            6'd35: return 32'hfde5380c;
            6'd36: return 32'ha4beea44;
            6'd37: return 32'h4bdecfa9;
            6'd38: return 32'hf6bb4b60;
            6'd39: return 32'hbebfbc70;
            6'd40: return 32'h289b7ec6;
            6'd41: return 32'heaa127fa;
            6'd42: return 32'hd4ef3085;
            6'd43: return 32'h04881d05;
            6'd44: return 32'hd9d4d039;
            6'd45: return 32'he6db99e5;
            6'd46: return 32'h1fa27cf8;
            6'd47: return 32'hc4ac5665;
            6'd48: return 32'hf4292244;
            6'd49: return 32'h432aff97;
            6'd50: return 32'hab9423a7;
            6'd51: return 32'hfc93a039;
            6'd52: return 32'h655b59c3;
            6'd53: return 32'h8f0ccc92;
            6'd54: return 32'hffeff47d;
            6'd55: return 32'h85845dd1;
            6'd56: return 32'h6fa87e4f;
            6'd57: return 32'hfe2ce6e0;
            6'd58: return 32'ha3014314;
            6'd59: return 32'h4e0811a1;
            6'd60: return 32'hf7537e82;
            6'd61: return 32'hbd3af235;
            6'd62: return 32'h2ad7d2bb;
            6'd63: return 32'heb86d391;
            default: return 32'h0;
        endcase
    endfunction

endpackage

/* sv/md5he_buf.sv */
// Block buffer of the MD5 engine: sixteen 32-bit words, written a byte at a time.
// Depends on md5he_pkg for the write port type.
module md5he_buf (
    input  logic               i_clk,
    input  md5he_pkg::t_buf_wr i_wr,
    input  logic [3:0]         i_rd_idx,
    output logic [31:0]        o_rd_word
);
    import md5he_pkg::*;

    logic [31:0] r_mem [16];
    logic [31:0] r_rd_word;

    // Byte 0 of a word sits in bits 7..0.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr[5:2]][{i_wr.addr[1:0], 3'b000} +: 8] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[i_rd_idx];
    end

    assign o_rd_word = r_rd_word;

endmodule

/* sv/md5he_round.sv */
// Shared MD5 round unit: each round sums its inputs, then rotates and shifts the words; 64 rounds per block.
// Depends on md5he_pkg for round constants, rotations and round functions.
module md5he_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  md5he_pkg::t_round_ctl i_ctl,
    input  md5he_pkg::t_words     i_chain,
    input  logic [31:0]           i_word,
    output logic [3:0]            o_word_idx,
    output md5he_pkg::t_words     o_work,
    output logic                  o_done
);
    import md5he_pkg::*;

    logic [31:0] r_a, r_b, r_c, r_d, r_t;
    logic [5:0]  r_round;
    logic        r_phase;
    logic [31:0] f_val;
    logic [5:0]  rd_round;

    assign f_val      = round_fn(r_round[5:4], r_b, r_c, r_d);
    // Fetch the word of the next round during the second half of this one.
    assign rd_round   = r_phase ? (r_round + 6'd1) : r_round;
    assign o_word_idx = msg_index(rd_round);
    assign o_done     = i_ctl.run && r_phase && (r_round == LAST_ROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_phase <= 1'b0;
        end else if (i_ctl.start) begin
            r_round <= '0;
            r_phase <= 1'b0;
        end else if (i_ctl.run) begin
            r_phase <= ~r_phase;
            if (r_phase) begin
                r_round <= r_round + 6'd1;
            end
        end
    end

    // First half sums the round inputs, second half rotates and shifts the words.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
        end else if (i_ctl.run) begin
            if (!r_phase) begin
                r_t <= r_a + f_val + i_word + round_const(r_round);
            end else begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + rotl32(r_t, rot_amount(r_round));
            end
        end
    end

    assign o_work[0] = r_a;
    assign o_work[1] = r_b;
    assign o_work[2] = r_c;
    assign o_work[3] = r_d;

endmodule

/* sv/md5_hash_engine_top.sv */
// Top level of the MD5 engine: sequencer, chaining words, byte count, padding.
// Depends on md5he_pkg, md5he_buf and md5he_round.
//
// Usage: the input channel (i_in_valid / o_in_ready) takes one transaction per
// message byte, with i_byte_valid telling whether i_message_byte carries a byte
// and i_end_of_message closing the message. After an ordinary byte the input
// stays ready. The byte that fills a 64-byte block starts a compression: 64
// rounds on the shared round unit, then a fold into the chaining words; the
// input is not ready until the fold is done. At end of message the sequencer
// writes pad bytes one per cycle up to the block end and runs one or two more
// compressions, then presents the four digest words A, B, C, D on the output
// channel (o_out_valid / i_out_ready) with o_last_word set on D. Input is held
// off while the digest is shown; a stalled receiver simply holds the current
// word. After D is taken the engine returns to the initial vector with a zero
// count and is ready again.
// Reset (synchronous, active low) restores the initial vector, clears the
// count and returns to idle; the block buffer is not cleared.
module md5_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic        o_last_word
);
    import md5he_pkg::*;

    t_state               r_state, n_state;
    t_words               r_chain, n_chain;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [5:0]           r_wpos, n_wpos;
    logic                 r_pad_first, n_pad_first;
    logic                 r_len_block, n_len_block;
    logic                 r_padding, n_padding;
    logic                 r_final, n_final;
    logic [1:0]           r_oidx, n_oidx;

    t_round_ctl  round_ctl;
    t_buf_wr     buf_wr;
    t_words      work;
    logic [3:0]  word_idx;
    logic [31:0] buf_word;
    logic        round_done;

    logic        in_acc, out_acc;
    logic [5:0]  byte_pos;
    logic        len_eff;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;

    md5he_buf u_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_idx  (word_idx),
        .o_rd_word (buf_word)
    );

    md5he_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (round_ctl),
        .i_chain    (r_chain),
        .i_word     (buf_word),
        .o_word_idx (word_idx),
        .o_work     (work),
        .o_done     (round_done)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = o_out_valid && i_out_ready;
    assign byte_pos = r_count[5:0];
    assign len_eff  = r_pad_first ? (r_wpos < LEN_POS) : r_len_block;
    assign len_bits = {r_count, 3'b000};

    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_MARK;
        end else if (len_eff && (r_wpos >= LEN_POS)) begin
            pad_byte = len_bits[{r_wpos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid && (byte_pos == LAST_POS)) begin
                        n_state = ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (round_done) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_padding) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (r_wpos == LAST_POS) begin
                    n_state = ST_ROUND;
                end
            end
            ST_OUT: begin
                if (out_acc && (r_oidx == LAST_OUT_IDX)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        round_ctl       = '0;
        buf_wr          = '0;
        n_chain         = r_chain;
        n_count         = r_count;
        n_wpos          = r_wpos;
        n_pad_first     = r_pad_first;
        n_len_block     = r_len_block;
        n_padding       = r_padding;
        n_final         = r_final;
        n_oidx          = r_oidx;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    if (i_byte_valid) begin
                        buf_wr.we   = 1'b1;
                        buf_wr.addr = byte_pos;
                        buf_wr.data = i_message_byte;
                        n_count     = r_count + 61'd1;
                        if (byte_pos == LAST_POS) begin
                            round_ctl.start = 1'b1;
                        end
                    end
                    if (i_end_of_message) begin
                        n_padding   = 1'b1;
                        n_pad_first = 1'b1;
                        n_wpos      = i_byte_valid ? byte_pos + 6'd1 : byte_pos;
                    end
                end
            end
            ST_ROUND: begin
                round_ctl.run = 1'b1;
            end
            ST_FOLD: begin
                n_chain[0] = r_chain[0] + work[0];
                n_chain[1] = r_chain[1] + work[1];
                n_chain[2] = r_chain[2] + work[2];
                n_chain[3] = r_chain[3] + work[3];
            end
            ST_PAD: begin
                buf_wr.we   = 1'b1;
                buf_wr.addr = r_wpos;
                buf_wr.data = pad_byte;
                n_pad_first = 1'b0;
                n_len_block = len_eff;
                n_wpos      = r_wpos + 6'd1;
                if (r_wpos == LAST_POS) begin
                    round_ctl.start = 1'b1;
                    n_final         = len_eff;
                    // no room for the length: it goes into the following block
                    if (!len_eff) begin
                        n_len_block = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (out_acc) begin
                    if (r_oidx == LAST_OUT_IDX) begin
                        n_chain   = IV_WORDS;
                        n_count   = '0;
                        n_padding = 1'b0;
                        n_final   = 1'b0;
                        n_oidx    = '0;
                    end else begin
                        n_oidx = r_oidx + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= IV_WORDS;
            r_count     <= '0;
            r_wpos      <= '0;
            r_pad_first <= 1'b0;
            r_len_block <= 1'b0;
            r_padding   <= 1'b0;
            r_final     <= 1'b0;
            r_oidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_count     <= n_count;
            r_wpos      <= n_wpos;
            r_pad_first <= n_pad_first;
            r_len_block <= n_len_block;
            r_padding   <= n_padding;
            r_final     <= n_final;
            r_oidx      <= n_oidx;
        end
    end

    assign o_digest_word = r_chain[r_oidx];
    assign o_last_word   = (r_oidx == LAST_OUT_IDX);

endmodule

/* sv/md5he_checker.sv */
// Port-level checks for the MD5 engine top level, attached by bind.
// Depends only on the ports of md5_hash_engine_top.
module md5he_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_end_of_message,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic        o_last_word
);

    // Accepting bytes and presenting the digest never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest is presented");

    // Hold a stalled digest word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_digest_word) && $stable(o_last_word)))
        else $error("stalled digest word changed");

    // Taking the last word returns the engine to accepting bytes.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> (o_in_ready && !o_out_valid))
        else $error("engine not ready after last digest word");

    // An end-of-message transaction starts padding or a compression, so input stalls next cycle.
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_end_of_message) |=> !o_in_ready)
        else $error("input ready right after end of message");

    // Reset leaves the engine idle and ready.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("engine not idle after reset");

endmodule

bind md5_hash_engine_top md5he_checker u_md5he_checker (.*);
